// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion forms
// Checks are sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------

// Same-cycle implication.
`define CFT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cft assertion failed");

// Next-cycle implication.
`define CFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cft assertion failed");

`endif

// ===== sv/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg: CSV field tokenizer shared types
// Action and result codes, the result record and the queued bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cft_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_EOL  = 2'd1,
    ACT_EOS  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_RECORD_END = 2'd2,
    KIND_EMPTY_LINE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } result_t;

  // One or two results caused by one input word.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

  localparam logic [7:0] LINE_FEED   = 8'h0A;
  localparam logic [1:0] KEEP_COLUMN = 2'd3;
  localparam logic [1:0] COLUMN_MAX  = 2'd3;
  localparam logic [7:0] SEP_RESET   = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_QUOTE     = 1'b1;

endpackage

`default_nettype wire

// ===== sv/cft_in_if.sv =====
// ----------------------------------------------------------------------------
// cft_in_if: text input channel
// Valid/ready channel carrying an action code and a text byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface cft_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink (input valid, input action, input char_in, output ready);
endinterface

`default_nettype wire

// ===== sv/cft_out_if.sv =====
// ----------------------------------------------------------------------------
// cft_out_if: token output channel
// Valid/ready channel carrying a token kind, a field byte and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cft_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output kind, output char_out, output last, input ready);
  modport sink (input valid, input kind, input char_out, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/cft_cfg.sv =====
// ----------------------------------------------------------------------------
// cft_cfg: configuration registers
// APB-style write and read of the separator and quote characters.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_cfg
  import cft_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [7:0]        sep_char,
  output logic      [7:0]        quote_char
);

  logic [7:0] sep_r;
  logic [7:0] quote_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= SEP_RESET;
      quote_r <= QUOTE_RESET;
    end else if (wr_en) begin
      if (reg_sel == REG_SEPARATOR) begin
        sep_r <= pwdata[7:0];
      end else begin
        quote_r <= pwdata[7:0];
      end
    end
  end

  assign prdata     = (reg_sel == REG_QUOTE) ? {24'd0, quote_r} : {24'd0, sep_r};
  assign sep_char   = sep_r;
  assign quote_char = quote_r;

endmodule

`default_nettype wire

// ===== sv/cft_front.sv =====
// ----------------------------------------------------------------------------
// cft_front: tokenizer front end
// Accepts input words, tracks quote and line state, and packs the one or
// two resulting tokens into a bundle for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_front
  import cft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  cft_in_if.sink          in_word,
  input  wire logic [7:0] sep_char,
  input  wire logic [7:0] quote_char,
  input  wire logic       q_full,
  output logic            push,
  output bundle_t         push_data
);

  logic       in_quotes_r,   in_quotes_nxt;
  logic       pend_r,        pend_nxt;
  logic       keepable_r,    keepable_nxt;
  logic [1:0] column_r,      column_nxt;
  logic [7:0] prev_byte_r,   prev_byte_nxt;
  logic       rec_started_r, rec_started_nxt;

  logic       accept;
  action_t    act;
  logic [7:0] c;
  logic       iq;
  logic       done;
  logic       pend_emit;
  result_t    pend_res;
  logic [1:0] main_n;
  result_t    m0;
  result_t    m1;

  assign in_word.ready = !q_full;
  assign accept        = in_word.valid && in_word.ready;
  assign act           = action_t'(in_word.action);
  assign c             = in_word.char_in;

  always_comb begin
    in_quotes_nxt   = in_quotes_r;
    pend_nxt        = pend_r;
    keepable_nxt    = keepable_r;
    column_nxt      = column_r;
    prev_byte_nxt   = prev_byte_r;
    rec_started_nxt = rec_started_r;
    iq              = in_quotes_r;
    done            = 1'b0;
    pend_emit       = 1'b0;
    pend_res        = '{kind: KIND_BYTE, ch: quote_char};
    main_n          = 2'd0;
    m0              = '{kind: KIND_BYTE, ch: 8'd0};
    m1              = '{kind: KIND_BYTE, ch: 8'd0};

    if (act != ACT_NONE) begin
      // resolve a held quote
      if (pend_r) begin
        pend_nxt     = 1'b0;
        keepable_nxt = 1'b0;
        if (act == ACT_BYTE && c == quote_char && in_quotes_r) begin
          pend_emit       = 1'b1;
          prev_byte_nxt   = c;
          column_nxt      = (column_r == COLUMN_MAX) ? COLUMN_MAX : column_r + 2'd1;
          rec_started_nxt = 1'b1;
          done            = 1'b1;
        end else begin
          iq = !in_quotes_r;
          if (act == ACT_BYTE && keepable_r && c != sep_char) begin
            pend_emit = 1'b1;
          end
        end
      end

      if (!done) begin
        in_quotes_nxt = iq;
        case (act)
          ACT_BYTE: begin
            if (c == quote_char) begin
              keepable_nxt = (column_r >= KEEP_COLUMN) && (prev_byte_r != sep_char);
              pend_nxt     = 1'b1;
            end else if (c == sep_char && !iq) begin
              main_n = 2'd1;
              m0     = '{kind: KIND_FIELD_END, ch: 8'd0};
            end else begin
              main_n = 2'd1;
              m0     = '{kind: KIND_BYTE, ch: c};
            end
            prev_byte_nxt   = c;
            column_nxt      = (column_r == COLUMN_MAX) ? COLUMN_MAX : column_r + 2'd1;
            rec_started_nxt = 1'b1;
          end
          ACT_EOL: begin
            main_n = 2'd1;
            if (iq) begin
              m0 = '{kind: KIND_BYTE, ch: LINE_FEED};
            end else begin
              m0 = '{kind: rec_started_r ? KIND_RECORD_END : KIND_EMPTY_LINE, ch: 8'd0};
              rec_started_nxt = 1'b0;
            end
            column_nxt    = 2'd0;
            prev_byte_nxt = 8'd0;
          end
          ACT_EOS: begin
            if (iq) begin
              if (column_r != 2'd0) begin
                main_n = 2'd2;
                m0     = '{kind: KIND_BYTE, ch: LINE_FEED};
                m1     = '{kind: KIND_RECORD_END, ch: 8'd0};
              end else begin
                main_n = 2'd1;
                m0     = '{kind: KIND_RECORD_END, ch: 8'd0};
              end
            end else if (rec_started_r) begin
              main_n = 2'd1;
              m0     = '{kind: KIND_RECORD_END, ch: 8'd0};
            end
            in_quotes_nxt   = 1'b0;
            pend_nxt        = 1'b0;
            keepable_nxt    = 1'b0;
            column_nxt      = 2'd0;
            prev_byte_nxt   = 8'd0;
            rec_started_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    if (pend_emit) begin
      push_data.two = (main_n != 2'd0);
      push_data.r0  = pend_res;
      push_data.r1  = m0;
    end else begin
      push_data.two = (main_n == 2'd2);
      push_data.r0  = m0;
      push_data.r1  = m1;
    end
  end

  assign push = accept && (pend_emit || main_n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r   <= 1'b0;
      pend_r        <= 1'b0;
      keepable_r    <= 1'b0;
      column_r      <= 2'd0;
      prev_byte_r   <= 8'd0;
      rec_started_r <= 1'b0;
    end else if (accept) begin
      in_quotes_r   <= in_quotes_nxt;
      pend_r        <= pend_nxt;
      keepable_r    <= keepable_nxt;
      column_r      <= column_nxt;
      prev_byte_r   <= prev_byte_nxt;
      rec_started_r <= rec_started_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cft_queue.sv =====
// ----------------------------------------------------------------------------
// cft_queue: token bundle queue
// Small FIFO of token bundles between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cft_queue
  import cft_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output bundle_t      head,
  output logic         empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `CFT_ASSERT_IMPL(a_push_not_full, push, !full)
  `CFT_ASSERT_IMPL(a_pop_not_empty, pop, !empty)
  `CFT_ASSERT_NEXT(a_push_fills, push && !pop, !empty)

endmodule

`default_nettype wire

// ===== sv/cft_back.sv =====
// ----------------------------------------------------------------------------
// cft_back: tokenizer back end
// Drains bundles from the queue and sends their tokens one per word
// through the output register, marking the last token of each bundle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cft_back
  import cft_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire bundle_t head,
  input  wire logic    empty,
  output logic         pop,
  cft_out_if.source    out_word
);

  logic    out_valid_r;
  result_t res_r;
  logic    last_r;
  logic    sub_r;

  logic    load;
  logic    take;
  logic    fin;
  result_t sel;

  assign load = !out_valid_r || out_word.ready;
  assign take = load && !empty;
  assign sel  = sub_r ? head.r1 : head.r0;
  assign fin  = !head.two || sub_r;
  assign pop  = take && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
      sub_r       <= !fin;
    end else if (load) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r  <= sel;
      last_r <= fin;
    end
  end

  assign out_word.valid    = out_valid_r;
  assign out_word.kind     = res_r.kind;
  assign out_word.char_out = res_r.ch;
  assign out_word.last     = last_r;

  `CFT_ASSERT_IMPL(a_sub_has_head, sub_r, !empty)
  `CFT_ASSERT_IMPL(a_sub_two, sub_r, head.two)

endmodule

`default_nettype wire

// ===== sv/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer: CSV stream to field and record tokens
// Input words carry a text byte, an end of line or an end of stream; output
// words carry field bytes, field ends, record ends and empty-line reports.
// The separator and quote bytes are set through the APB-style port.
//
// in_word:  valid/ready; action and char_in, taken when valid and ready.
// out_word: valid/ready; kind, char_out and last, last set on the final
//           token caused by one input word.
// With the queue empty, the first token of an accepted input word is written
// into the queue, then loaded into the output register and shown on out_word.
// Input is taken at one word per cycle while the queue has room; output runs
// at one token per cycle while the receiver is ready, so a word giving two
// tokens takes two output words and the bundle queue absorbs the difference.
// A quote byte produces its token only when the following word arrives.
// A stalled out_word holds its token; the queue fills and then in_word.ready
// drops until the receiver takes words again.
// Reset (rst_n low, synchronous) clears quote and line state, empties the
// queue and restores comma and double quote as separator and quote.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer
  import cft_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  cft_in_if.sink                 in_word,
  cft_out_if.source              out_word,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [7:0] sep_char;
  logic [7:0] quote_char;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  bundle_t    push_data;
  bundle_t    head;

  cft_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .sep_char   (sep_char),
    .quote_char (quote_char)
  );

  cft_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .sep_char   (sep_char),
    .quote_char (quote_char),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  cft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  cft_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

// ===== test/csv_field_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_tb: self-checking bench for the CSV field tokenizer
// Drives action/byte words through the input channel and predicts the
// field bytes, field ends, record ends and empty-line reports that the
// tokenizer must emit, comparing every output word in order. Covers the
// register port, directed quoting corner cases, random well-formed records
// mixed with noise under several separator/quote settings, random idling
// on both channels, full-rate bursts and a pause until all output drains.
// ----------------------------------------------------------------------------

module csv_field_tokenizer_tb;
  import cft_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [1:0] KEEP_FROM_COLUMN = 2'd3;
  localparam logic [7:0] DEFAULT_SEP = 8'd44;
  localparam logic [7:0] DEFAULT_QUOTE = 8'd34;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  cft_in_if in_word();
  cft_out_if out_word();

  csv_field_tokenizer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .out_word(out_word),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0] sep_reg = DEFAULT_SEP;
  logic [7:0] quote_reg = DEFAULT_QUOTE;
  bit in_quotes = 1'b0;
  bit quote_held = 1'b0;
  bit held_keepable = 1'b0;
  bit rec_open = 1'b0;
  logic [1:0] column = 2'd0;
  logic [7:0] prev_byte = 8'd0;

  token_t expected_tokens[$];
  int fails = 0;
  int words_sent = 0;
  int in_gap_max = 15;
  int out_stall_max = 15;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic token_t make_token(kind_t k, logic [7:0] c);
    token_t t;
    t.kind = k;
    t.ch = c;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic void note_byte(logic [7:0] c);
    prev_byte = c;
    if (column < 2'd3) column++;
    rec_open = 1'b1;
  endfunction

  function automatic void tokenize(action_t act, logic [7:0] c);
    token_t toks[$];
    bit keep;
    bit done;
    done = 1'b0;
    if (act == ACT_NONE) return;
    if (quote_held) begin
      keep = held_keepable;
      quote_held = 1'b0;
      held_keepable = 1'b0;
      if (act == ACT_BYTE && c == quote_reg && in_quotes) begin
        toks = {toks, make_token(KIND_BYTE, quote_reg)};
        note_byte(c);
        done = 1'b1;
      end else begin
        in_quotes = !in_quotes;
        if (act == ACT_BYTE && keep && c != sep_reg)
          toks = {toks, make_token(KIND_BYTE, quote_reg)};
      end
    end
    if (!done) begin
      case (act)
        ACT_BYTE: begin
          if (c == quote_reg) begin
            held_keepable = (column >= KEEP_FROM_COLUMN) && (prev_byte != sep_reg);
            quote_held = 1'b1;
          end else if (c == sep_reg && !in_quotes) begin
            toks = {toks, make_token(KIND_FIELD_END, 8'd0)};
          end else begin
            toks = {toks, make_token(KIND_BYTE, c)};
          end
          note_byte(c);
        end
        ACT_EOL: begin
          if (in_quotes) begin
            toks = {toks, make_token(KIND_BYTE, NEWLINE)};
          end else begin
            toks = {toks,
                    make_token(rec_open ? KIND_RECORD_END : KIND_EMPTY_LINE, 8'd0)};
            rec_open = 1'b0;
          end
          column = 2'd0;
          prev_byte = 8'd0;
        end
        default: begin
          if (in_quotes) begin
            if (column != 2'd0) toks = {toks, make_token(KIND_BYTE, NEWLINE)};
            toks = {toks, make_token(KIND_RECORD_END, 8'd0)};
          end else if (rec_open) begin
            toks = {toks, make_token(KIND_RECORD_END, 8'd0)};
          end
          in_quotes = 1'b0;
          quote_held = 1'b0;
          held_keepable = 1'b0;
          column = 2'd0;
          prev_byte = 8'd0;
          rec_open = 1'b0;
        end
      endcase
    end
    if (toks.size() > 0) begin
      toks[toks.size() - 1].last = 1'b1;
      expected_tokens = {expected_tokens, toks};
    end
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom);
      else c = 8'($urandom_range(8'h61, 8'h7A));
    end while (c == sep_reg || c == quote_reg);
    return c;
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 4))
      0: return sep_reg;
      1: return quote_reg;
      2: return 8'($urandom);
      default: return pick_plain();
    endcase
  endfunction

  task automatic send_word(action_t act, logic [7:0] c);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_word.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word.valid = 1'b1;
    in_word.action = act;
    in_word.char_in = c;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    tokenize(act, c);
    if (act != ACT_NONE) words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_word.valid = 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'({idx, 2'b00});
    pwdata = {24'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_SEPARATOR) sep_reg = value;
    else quote_reg = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_reg(logic idx, logic [7:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'd0, value}) begin
      $display("%0t: register %0d mismatch, expected %08h, actual %08h",
               $time, idx, {24'd0, value}, prdata);
      fails++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(logic [7:0] sep, logic [7:0] quote);
    send_word(ACT_EOS, 8'd0);
    drain();
    write_reg(REG_SEPARATOR, sep);
    write_reg(REG_QUOTE, quote);
    check_reg(REG_SEPARATOR, sep);
    check_reg(REG_QUOTE, quote);
  endtask

  task automatic send_record();
    int nf;
    int nc;
    nf = $urandom_range(1, 4);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) send_word(ACT_BYTE, sep_reg);
      nc = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
        send_word(ACT_BYTE, quote_reg);
        for (int j = 0; j < nc; j++) begin
          case ($urandom_range(0, 7))
            0: begin
              send_word(ACT_BYTE, quote_reg);
              send_word(ACT_BYTE, quote_reg);
            end
            1: send_word(ACT_BYTE, sep_reg);
            2: send_word(ACT_EOL, 8'($urandom));
            default: send_word(ACT_BYTE, pick_plain());
          endcase
        end
        send_word(ACT_BYTE, quote_reg);
      end else begin
        for (int j = 0; j < nc; j++) begin
          if ($urandom_range(0, 9) == 0) send_word(ACT_BYTE, quote_reg);
          else send_word(ACT_BYTE, pick_plain());
        end
      end
    end
    if ($urandom_range(0, 9) == 0) send_word(ACT_EOS, 8'($urandom));
    else send_word(ACT_EOL, 8'($urandom));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0: send_word(ACT_NONE, 8'($urandom));
        1: send_word(ACT_EOS, 8'($urandom));
        2, 3: send_word(ACT_EOL, 8'($urandom));
        default: send_word(ACT_BYTE, pick_noise());
      endcase
    end
  endtask

  task automatic run_random(int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(0, 3) != 0) send_record();
      else send_noise();
    end
  endtask

  task automatic test_register_access();
    check_reg(REG_SEPARATOR, DEFAULT_SEP);
    check_reg(REG_QUOTE, DEFAULT_QUOTE);
    write_reg(REG_SEPARATOR, 8'h3B);
    write_reg(REG_QUOTE, 8'h27);
    check_reg(REG_SEPARATOR, 8'h3B);
    check_reg(REG_QUOTE, 8'h27);
    write_reg(REG_SEPARATOR, DEFAULT_SEP);
    write_reg(REG_QUOTE, DEFAULT_QUOTE);
  endtask

  task automatic test_directed();
    send_word(ACT_EOL, 8'h00);
    send_word(ACT_EOS, 8'hFF);
    send_word(ACT_BYTE, "a");
    send_word(ACT_BYTE, sep_reg);
    send_word(ACT_BYTE, quote_reg);
    send_word(ACT_BYTE, "z");
    send_word(ACT_BYTE, quote_reg);
    send_word(ACT_BYTE, quote_reg);
    send_word(ACT_BYTE, quote_reg);
    send_word(ACT_EOL, 8'h00);
    send_word(ACT_BYTE, "a");
    send_word(ACT_BYTE, "b");
    send_word(ACT_BYTE, "c");
    send_word(ACT_BYTE, quote_reg);
    send_word(ACT_BYTE, "d");
    send_word(ACT_EOL, 8'h00);
    send_word(ACT_EOS, 8'h00);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, "x");
    send_word(ACT_BYTE, quote_reg);
    send_word(ACT_BYTE, quote_reg);
    send_word(ACT_NONE, 8'h5A);
    send_word(ACT_EOS, 8'h00);
  endtask

  task automatic test_random_defaults();
    run_random(250);
  endtask

  task automatic test_config_extremes();
    logic [7:0] seps[4];
    logic [7:0] quotes[4];
    seps = '{8'h00, 8'hFF, 8'h2C, 8'hFF};
    quotes = '{8'hFF, 8'h00, 8'h2C, 8'hFF};
    foreach (seps[i]) begin
      set_config(seps[i], quotes[i]);
      repeat (3) send_word(ACT_BYTE, pick_plain());
      send_word(ACT_BYTE, quote_reg);
      send_word(ACT_BYTE, sep_reg);
      send_word(ACT_EOL, 8'h00);
      run_random(80);
    end
    set_config(DEFAULT_SEP, DEFAULT_QUOTE);
  endtask

  task automatic test_full_rate();
    in_gap_max = 0;
    out_stall_max = 0;
    run_random(120);
    out_stall_max = 15;
    run_random(80);
    in_gap_max = 15;
  endtask

  task automatic test_pause();
    run_random(40);
    drain();
    run_random(40);
  endtask

  initial begin
    int stall;
    out_word.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      repeat (stall) begin
        @(negedge clk);
        out_word.ready = 1'b0;
      end
      @(negedge clk);
      out_word.ready = 1'b1;
      @(posedge clk);
      while (!out_word.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d char %02h last %0b",
                 $time, out_word.kind, out_word.char_out, out_word.last);
        fails++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_word.kind !== want.kind) begin
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, out_word.kind);
          fails++;
        end
        if (out_word.char_out !== want.ch) begin
          $display("%0t: char_out mismatch, expected %02h, actual %02h",
                   $time, want.ch, out_word.char_out);
          fails++;
        end
        if (out_word.last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, want.last, out_word.last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_word.valid && in_word.ready) ||
        (out_word.valid && out_word.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_word.valid = 1'b0;
    in_word.action = ACT_BYTE;
    in_word.char_in = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_register_access();
    test_directed();
    test_random_defaults();
    test_config_extremes();
    test_full_rate();
    test_pause();
    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
